// ===== design/ycbcr_to_rgb_framebuffer_writer_macros.svh =====
// Assertion macros shared by the converter's modules.
// Each macro expects clk_i and rst_ni in scope.
`ifndef YCBCR_TO_RGB_FRAMEBUFFER_WRITER_MACROS_SVH
`define YCBCR_TO_RGB_FRAMEBUFFER_WRITER_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define YCRGBFW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define YCRGBFW_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== design/ycrgbfw_pkg.sv =====
`timescale 1ns / 1ps
package ycrgbfw_pkg;

  // Crop window.
  localparam int MAX_WIDTH  = 720;
  localparam int MAX_HEIGHT = 576;

  // Field widths.
  localparam int DIM_W     = 12;
  localparam int CNT_W     = DIM_W + 1;
  localparam int SAMPLE_W  = 8;
  localparam int PIX_W     = 24;
  localparam int OFS_W     = 21;
  localparam int CFG_IDX_W = 2;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int ROWMW_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);

  // Register reset values.
  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(352);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(240);

  // Fixed-point datapath widths.
  localparam int PROD_W = 20;
  localparam int SUM_W  = 22;
  localparam int FRAC_W = 10;

  // BT.601 limited-range coefficients, scaled by 1024.
  localparam logic signed [PROD_W-1:0] K_LUMA     = PROD_W'(1192);
  localparam logic signed [PROD_W-1:0] K_RED_CR   = PROD_W'(1634);
  localparam logic signed [PROD_W-1:0] K_GREEN_CB = PROD_W'(400);
  localparam logic signed [PROD_W-1:0] K_GREEN_CR = PROD_W'(833);
  localparam logic signed [PROD_W-1:0] K_BLUE_CB  = PROD_W'(2066);
  localparam logic signed [PROD_W-1:0] LUMA_BLACK = PROD_W'(16);
  localparam logic signed [PROD_W-1:0] CHROMA_MID = PROD_W'(128);

  // Queue geometry, used for both the command and the result queue.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = Q_AW + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_OUTPUT_XRGB   = 2'd2
  } cfg_reg_e;

  // One kept pixel, as handed from the front to the back.
  typedef struct packed {
    logic [SAMPLE_W-1:0] luma;
    logic [SAMPLE_W-1:0] blue_diff;
    logic [SAMPLE_W-1:0] red_diff;
    logic                xrgb;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic                last;
  } pix_cmd_t;

  // One finished result item.
  typedef struct packed {
    logic [PIX_W-1:0] pixel_word;
    logic [OFS_W-1:0] byte_offset;
    logic             last_pixel;
  } pix_res_t;

  // Floor-shift by the coefficient scale and clamp to 0..255.
  function automatic logic [SAMPLE_W-1:0] sat_channel(input logic signed [SUM_W-1:0] sum);
    logic signed [SUM_W-1:0] q;
    q = sum >>> FRAC_W;
    if (sum < 0) begin
      return '0;
    end else if (q > $signed(SUM_W'(255))) begin
      return '1;
    end else begin
      return q[SAMPLE_W-1:0];
    end
  endfunction

endpackage

// ===== design/ycrgbfw_front.sv =====
`timescale 1ns / 1ps
module ycrgbfw_front import ycrgbfw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  logic [SAMPLE_W-1:0]  luma_i,
  input  logic [SAMPLE_W-1:0]  blue_diff_i,
  input  logic [SAMPLE_W-1:0]  red_diff_i,
  output logic                 cmd_push_o,
  output pix_cmd_t             cmd_o,
  input  logic                 cmd_full_i
);

  logic [DIM_W-1:0] width_q, height_q;
  logic             xrgb_q;
  logic [DIM_W-1:0] col_q, col_d, row_q, row_d;
  logic [CNT_W-1:0] w_eff, h_eff, kw, kh, col_inc, row_inc;
  logic             accept, keep, last;

  assign cfg_ready_o = 1'b1;
  assign full        = cmd_full_i;
  assign accept      = push && !cmd_full_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      xrgb_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SOURCE_WIDTH:  width_q  <= cfg_data_i;
        REG_SOURCE_HEIGHT: height_q <= cfg_data_i;
        REG_OUTPUT_XRGB:   xrgb_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A size of zero stands for 4096; the kept area is the size clipped to the crop window.
  always_comb begin
    w_eff   = (width_q == '0) ? CNT_W'(4096) : CNT_W'(width_q);
    h_eff   = (height_q == '0) ? CNT_W'(4096) : CNT_W'(height_q);
    kw      = (w_eff < CNT_W'(MAX_WIDTH)) ? w_eff : CNT_W'(MAX_WIDTH);
    kh      = (h_eff < CNT_W'(MAX_HEIGHT)) ? h_eff : CNT_W'(MAX_HEIGHT);
    col_inc = CNT_W'(col_q) + CNT_W'(1);
    row_inc = CNT_W'(row_q) + CNT_W'(1);
    keep    = (col_q < DIM_W'(MAX_WIDTH)) && (row_q < DIM_W'(MAX_HEIGHT));
    last    = (CNT_W'(col_q) == kw - CNT_W'(1)) && (CNT_W'(row_q) == kh - CNT_W'(1));
  end

  // Raster position for the next pixel: wrap the column at the line end, the row at frame end.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = (row_inc >= h_eff) ? '0 : row_inc[DIM_W-1:0];
      end else begin
        col_d = col_inc[DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Kept pixels go into the command queue with their position and format.
  assign cmd_push_o      = accept && keep;
  assign cmd_o.luma      = luma_i;
  assign cmd_o.blue_diff = blue_diff_i;
  assign cmd_o.red_diff  = red_diff_i;
  assign cmd_o.xrgb      = xrgb_q;
  assign cmd_o.col       = col_q[COL_W-1:0];
  assign cmd_o.row       = row_q[ROW_W-1:0];
  assign cmd_o.last      = last;

endmodule

// ===== design/ycrgbfw_fifo.sv =====
`timescale 1ns / 1ps
`include "ycbcr_to_rgb_framebuffer_writer_macros.svh"
module ycrgbfw_fifo import ycrgbfw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pix_cmd_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output pix_cmd_t data_o,
  output logic     empty_o
);

  pix_cmd_t          mem_q [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_CW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == Q_CW'(Q_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Item storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + Q_CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - Q_CW'(1);
      end
    end
  end

  `YCRGBFW_ASSERT(a_push_fills, do_push |=> !empty_o, "command queue empty after a push")
  `YCRGBFW_ASSERT_NEVER(a_count_range, count_q > Q_CW'(Q_DEPTH), "command queue overfilled")

endmodule

// ===== design/ycrgbfw_back.sv =====
`timescale 1ns / 1ps
`include "ycbcr_to_rgb_framebuffer_writer_macros.svh"
module ycrgbfw_back import ycrgbfw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pix_cmd_t         cmd_i,
  input  logic             cmd_empty_i,
  output logic             cmd_pop_o,
  input  logic             pop,
  output logic             empty,
  output logic [PIX_W-1:0] pixel_word_o,
  output logic [OFS_W-1:0] byte_offset_o,
  output logic             last_pixel_o
);

  logic                      s1_valid_q;
  logic signed [PROD_W-1:0]  s1_yy_q, s1_rv_q, s1_gu_q, s1_gv_q, s1_bu_q;
  logic [ROWMW_W-1:0]        s1_rowmw_q;
  logic [COL_W-1:0]          s1_col_q;
  logic                      s1_xrgb_q, s1_last_q;
  logic signed [PROD_W-1:0]  y_s, u_s, v_s;
  logic signed [SUM_W-1:0]   r_sum, g_sum, b_sum;
  logic [SAMPLE_W-1:0]       r_ch, g_ch, b_ch;
  logic [OFS_W-1:0]          ofs_base;
  pix_res_t                  res;
  pix_res_t                  out_mem_q [Q_DEPTH];
  logic [Q_AW-1:0]           out_wr_q, out_rd_q;
  logic [Q_CW-1:0]           out_cnt_q;
  logic                      take, out_pop;

  // Take a command only when the result queue has room for it and the one in flight.
  assign take      = !cmd_empty_i &&
                     ((out_cnt_q + Q_CW'(s1_valid_q)) < Q_CW'(Q_DEPTH));
  assign cmd_pop_o = take;

  // Stage one: remove offsets and form the coefficient products and the row base.
  always_comb begin
    y_s = signed'(PROD_W'(cmd_i.luma)) - LUMA_BLACK;
    u_s = signed'(PROD_W'(cmd_i.blue_diff)) - CHROMA_MID;
    v_s = signed'(PROD_W'(cmd_i.red_diff)) - CHROMA_MID;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_yy_q    <= y_s * K_LUMA;
      s1_rv_q    <= v_s * K_RED_CR;
      s1_gu_q    <= u_s * K_GREEN_CB;
      s1_gv_q    <= v_s * K_GREEN_CR;
      s1_bu_q    <= u_s * K_BLUE_CB;
      s1_rowmw_q <= ROWMW_W'(cmd_i.row) * ROWMW_W'(MAX_WIDTH);
      s1_col_q   <= cmd_i.col;
      s1_xrgb_q  <= cmd_i.xrgb;
      s1_last_q  <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= take;
    end
  end

  // Stage two: channel sums, clamp, pack and the byte address.
  always_comb begin
    r_sum = SUM_W'(s1_yy_q) + SUM_W'(s1_rv_q);
    g_sum = SUM_W'(s1_yy_q) - SUM_W'(s1_gu_q) - SUM_W'(s1_gv_q);
    b_sum = SUM_W'(s1_yy_q) + SUM_W'(s1_bu_q);
    r_ch  = sat_channel(r_sum);
    g_ch  = sat_channel(g_sum);
    b_ch  = sat_channel(b_sum);
    ofs_base = OFS_W'(s1_rowmw_q) + OFS_W'(s1_col_q);
    if (s1_xrgb_q) begin
      res.pixel_word  = {r_ch, g_ch, b_ch};
      res.byte_offset = ofs_base << 2;
    end else begin
      // RGB565 keeps the top five, six and five bits of red, green and blue.
      res.pixel_word  = {8'h00, r_ch[7:3], g_ch[7:2], b_ch[7:3]};
      res.byte_offset = ofs_base << 1;
    end
    res.last_pixel = s1_last_q;
  end

  // Result queue storage.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      out_mem_q[out_wr_q] <= res;
    end
  end

  assign empty   = (out_cnt_q == '0);
  assign out_pop = pop && !empty;

  // Result queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (s1_valid_q) begin
        out_wr_q <= out_wr_q + Q_AW'(1);
      end
      if (out_pop) begin
        out_rd_q <= out_rd_q + Q_AW'(1);
      end
      if (s1_valid_q && !out_pop) begin
        out_cnt_q <= out_cnt_q + Q_CW'(1);
      end else if (out_pop && !s1_valid_q) begin
        out_cnt_q <= out_cnt_q - Q_CW'(1);
      end
    end
  end

  assign pixel_word_o  = out_mem_q[out_rd_q].pixel_word;
  assign byte_offset_o = out_mem_q[out_rd_q].byte_offset;
  assign last_pixel_o  = out_mem_q[out_rd_q].last_pixel;

  `YCRGBFW_ASSERT(a_room_for_flight, s1_valid_q |-> (out_cnt_q < Q_CW'(Q_DEPTH)),
                  "result in flight with no room in the result queue")
  `YCRGBFW_ASSERT_NEVER(a_out_range, out_cnt_q > Q_CW'(Q_DEPTH), "result queue overfilled")

endmodule

// ===== design/ycbcr_to_rgb_framebuffer_writer.sv =====
`timescale 1ns / 1ps
// Channel   | Handshake                  | Content
// ----------+----------------------------+-------------------------------------------
// pixel in  | push / full                | luma_i, blue_diff_i, red_diff_i
// result    | empty / pop                | pixel_word_o, byte_offset_o, last_pixel_o
// config    | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One item is accepted per clock while full is low; a kept pixel passes through the command
// queue, the product register and the result queue before it shows on the result ports.
// Cropped pixels only advance the raster counters and give no result; cfg_ready_o is always high.
// Reset clears the counters and both four-entry queues and loads the register defaults.
// The front stalls only when the command queue is full; the back stops taking commands when
// the result queue cannot hold the pixel in flight, so a stalled reader fills both queues.
module ycbcr_to_rgb_framebuffer_writer import ycrgbfw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  logic [SAMPLE_W-1:0]  luma_i,
  input  logic [SAMPLE_W-1:0]  blue_diff_i,
  input  logic [SAMPLE_W-1:0]  red_diff_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [PIX_W-1:0]     pixel_word_o,
  output logic [OFS_W-1:0]     byte_offset_o,
  output logic                 last_pixel_o
);

  pix_cmd_t cmd_in, cmd_out;
  logic     cmd_push, cmd_full, cmd_pop, cmd_empty;

  // Front: configuration, raster counters and crop decision.
  ycrgbfw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .luma_i      (luma_i),
    .blue_diff_i (blue_diff_i),
    .red_diff_i  (red_diff_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full)
  );

  // Command queue between the two halves.
  ycrgbfw_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // Back: colour conversion, packing, addressing and the result queue.
  ycrgbfw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_out),
    .cmd_empty_i   (cmd_empty),
    .cmd_pop_o     (cmd_pop),
    .pop           (pop),
    .empty         (empty),
    .pixel_word_o  (pixel_word_o),
    .byte_offset_o (byte_offset_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

// ===== bench/pixel_result_checker.sv =====
`timescale 1ns / 1ps
// Watches the pixel, configuration and result channels of the converter, works out the
// expected result item for every kept pixel and compares each popped result with it.
module pixel_result_checker import ycrgbfw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic                 push_i,
  input  logic                 full_i,
  input  logic [SAMPLE_W-1:0]  luma_i,
  input  logic [SAMPLE_W-1:0]  blue_diff_i,
  input  logic [SAMPLE_W-1:0]  red_diff_i,
  input  logic                 empty_i,
  input  logic                 pop_i,
  input  logic [PIX_W-1:0]     pixel_word_i,
  input  logic [OFS_W-1:0]     byte_offset_i,
  input  logic                 last_pixel_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  // Results still owed by the block, oldest first.
  pix_res_t         owed_pixels_q[$];

  // Mirror of the configuration registers and the raster position.
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic             xrgb_reg;
  int               col_cnt;
  int               row_cnt;
  int               fails;

  // Drop the fraction of a scaled channel sum and clamp it to a byte.
  function automatic logic [SAMPLE_W-1:0] clamp_channel(input int sum);
    int q;
    if (sum < 0) begin
      return '0;
    end
    q = sum >>> FRAC_W;
    if (q > 255) begin
      return '1;
    end
    return q[SAMPLE_W-1:0];
  endfunction

  // A size register of zero stands for the full 12-bit range.
  function automatic int frame_dim(input logic [DIM_W-1:0] value);
    return (value == '0) ? 4096 : int'(value);
  endfunction

  // Colour conversion, packing and framebuffer address of one kept pixel.
  function automatic pix_res_t convert_pixel(input logic [SAMPLE_W-1:0] y,
                                             input logic [SAMPLE_W-1:0] cb,
                                             input logic [SAMPLE_W-1:0] cr,
                                             input logic xrgb, input int col, input int row,
                                             input int kept_w, input int kept_h);
    int               yy;
    int               du;
    int               dv;
    int               bpp;
    logic [SAMPLE_W-1:0] r;
    logic [SAMPLE_W-1:0] g;
    logic [SAMPLE_W-1:0] b;
    pix_res_t         res;
    yy = (int'(y) - 16) * int'(K_LUMA);
    du = int'(cb) - 128;
    dv = int'(cr) - 128;
    r  = clamp_channel(yy + int'(K_RED_CR) * dv);
    g  = clamp_channel(yy - int'(K_GREEN_CB) * du - int'(K_GREEN_CR) * dv);
    b  = clamp_channel(yy + int'(K_BLUE_CB) * du);
    if (xrgb) begin
      res.pixel_word = {r, g, b};
      bpp = 4;
    end else begin
      res.pixel_word = {8'h00, r[7:3], g[7:2], b[7:3]};
      bpp = 2;
    end
    res.byte_offset = OFS_W'(row * MAX_WIDTH * bpp + col * bpp);
    res.last_pixel  = (col == kept_w - 1) && (row == kept_h - 1);
    return res;
  endfunction

  // Results are checked before the pixel of the same edge is counted, since a pixel
  // can never come out in the cycle that takes it.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    pix_res_t owed;
    int       w;
    int       h;
    if (!rst_ni) begin
      owed_pixels_q.delete();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      xrgb_reg   = 1'b0;
      col_cnt    = 0;
      row_cnt    = 0;
      fails      = 0;
    end else begin
      // Result side.
      if (pop_i && !empty_i) begin
        if (owed_pixels_q.size() == 0) begin
          $display("%0t: result item with no pixel owed: word %h offset %h last %b",
                   $time, pixel_word_i, byte_offset_i, last_pixel_i);
          fails++;
        end else begin
          owed = owed_pixels_q.pop_front();
          if (pixel_word_i !== owed.pixel_word) begin
            $display("%0t: pixel_word expected %h, got %h",
                     $time, owed.pixel_word, pixel_word_i);
            fails++;
          end
          if (byte_offset_i !== owed.byte_offset) begin
            $display("%0t: byte_offset expected %h, got %h",
                     $time, owed.byte_offset, byte_offset_i);
            fails++;
          end
          if (last_pixel_i !== owed.last_pixel) begin
            $display("%0t: last_pixel expected %b, got %b",
                     $time, owed.last_pixel, last_pixel_i);
            fails++;
          end
        end
      end

      // Register writes.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SOURCE_WIDTH:  width_reg  = cfg_data_i;
          REG_SOURCE_HEIGHT: height_reg = cfg_data_i;
          REG_OUTPUT_XRGB:   xrgb_reg   = cfg_data_i[0];
          default: ;
        endcase
      end

      // Pixel side: predict kept pixels and advance the raster counters for every accepted pixel.
      if (push_i && !full_i) begin
        w = frame_dim(width_reg);
        h = frame_dim(height_reg);
        if (col_cnt < MAX_WIDTH && row_cnt < MAX_HEIGHT) begin
          owed_pixels_q.push_back(convert_pixel(luma_i, blue_diff_i, red_diff_i, xrgb_reg,
                                                col_cnt, row_cnt,
                                                (w < MAX_WIDTH) ? w : MAX_WIDTH,
                                                (h < MAX_HEIGHT) ? h : MAX_HEIGHT));
        end
        if (col_cnt + 1 >= w) begin
          col_cnt = 0;
          row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
        end else begin
          col_cnt = col_cnt + 1;
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= owed_pixels_q.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Drives pixel items and register writes into the converter, stalls the result side on
// its own pattern and gives the verdict from the checker's failure count.
module tb import ycrgbfw_pkg::*;;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 1950;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  logic                 push;
  logic                 full;
  logic [SAMPLE_W-1:0]  luma;
  logic [SAMPLE_W-1:0]  blue_diff;
  logic [SAMPLE_W-1:0]  red_diff;
  logic                 empty;
  logic                 pop;
  logic [PIX_W-1:0]     pixel_word;
  logic [OFS_W-1:0]     byte_offset;
  logic                 last_pixel;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int burst_left;
  int random_sent = 0;

  // Directed samples: all-zero, all-one, black, white, saturating corners, mid tones.
  logic [SAMPLE_W-1:0] dir_luma[8]      = '{8'd0, 8'd255, 8'd16, 8'd235, 8'd255, 8'd0, 8'd81, 8'd145};
  logic [SAMPLE_W-1:0] dir_blue_diff[8] = '{8'd0, 8'd255, 8'd128, 8'd128, 8'd0, 8'd255, 8'd90, 8'd54};
  logic [SAMPLE_W-1:0] dir_red_diff[8]  = '{8'd0, 8'd255, 8'd128, 8'd128, 8'd255, 8'd0, 8'd240, 8'd34};

  ycbcr_to_rgb_framebuffer_writer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .push          (push),
    .full          (full),
    .luma_i        (luma),
    .blue_diff_i   (blue_diff),
    .red_diff_i    (red_diff),
    .empty         (empty),
    .pop           (pop),
    .pixel_word_o  (pixel_word),
    .byte_offset_o (byte_offset),
    .last_pixel_o  (last_pixel)
  );

  pixel_result_checker result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .push_i        (push),
    .full_i        (full),
    .luma_i        (luma),
    .blue_diff_i   (blue_diff),
    .red_diff_i    (red_diff),
    .empty_i       (empty),
    .pop_i         (pop),
    .pixel_word_i  (pixel_word),
    .byte_offset_i (byte_offset),
    .last_pixel_i  (last_pixel),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Cycle counter and watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb failed");
    $finish;
  end

  // Result side: runs of free flow, random popping, sparse popping and hard stalls.
  initial begin : reader
    int mode;
    int span;
    pop <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          2:       pop <= ($urandom_range(0, 7) == 0);
          default: pop <= 1'b0;
        endcase
      end
    end
  end

  // A sample value with a bias towards the ends of the range and the limited-range levels.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd16;
      3:       return 8'd235;
      default: return SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one pixel item and hold it until it is taken.
  task automatic send_pixel(input logic [SAMPLE_W-1:0] y, input logic [SAMPLE_W-1:0] cb,
                            input logic [SAMPLE_W-1:0] cr);
    push      <= 1'b1;
    luma      <= y;
    blue_diff <= cb;
    red_diff  <= cr;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      push <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Random pixels in bursts of random length, with gaps in between.
  task automatic send_stream(input int count);
    for (int i = 0; i < count; i++) begin
      send_pixel(pick_sample(), pick_sample(), pick_sample());
      random_sent++;
      burst_left--;
      if (burst_left <= 0) begin
        pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 24);
      end
    end
  endtask

  // Stop sending, wait for every owed result, then let any cropped pixel drain.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e index, input logic [DIM_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int kind;
    int count;
    rst_ni     <= 1'b0;
    push       <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_SOURCE_WIDTH;
    cfg_data   <= '0;
    luma       <= '0;
    blue_diff  <= '0;
    red_diff   <= '0;
    burst_left = 8;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners, first under the reset settings, then in XRGB.
    foreach (dir_luma[i]) send_pixel(dir_luma[i], dir_blue_diff[i], dir_red_diff[i]);
    settle();
    write_reg(REG_OUTPUT_XRGB, DIM_W'(1));
    foreach (dir_luma[i]) send_pixel(dir_luma[i], dir_blue_diff[i], dir_red_diff[i]);
    settle();

    // Lines wider than the crop window: cropped columns and the last pixel at the edge.
    write_reg(REG_SOURCE_WIDTH, DIM_W'(725));
    write_reg(REG_SOURCE_HEIGHT, DIM_W'(1));
    send_stream(730);
    settle();

    // Zero sizes count as the full range, so the line must not wrap early.
    write_reg(REG_SOURCE_WIDTH, DIM_W'(0));
    write_reg(REG_SOURCE_HEIGHT, DIM_W'(0));
    write_reg(REG_OUTPUT_XRGB, DIM_W'(0));
    send_stream(40);
    settle();

    // One pixel per line with a tall picture: the column wraps at once, rows pass the crop.
    write_reg(REG_SOURCE_WIDTH, DIM_W'(1));
    send_stream(600);
    settle();

    // Random phases, mostly small pictures so that frames wrap often.
    while (random_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 11);
      if (kind <= 6) begin
        write_reg(REG_SOURCE_WIDTH, DIM_W'($urandom_range(1, 24)));
        write_reg(REG_SOURCE_HEIGHT, DIM_W'($urandom_range(1, 10)));
        write_reg(REG_OUTPUT_XRGB, DIM_W'($urandom_range(0, 1)));
        count = $urandom_range(30, 90);
      end else if (kind == 7) begin
        // Format change in the middle of a frame.
        write_reg(REG_OUTPUT_XRGB, DIM_W'($urandom_range(0, 1)));
        count = 40;
      end else if (kind == 8) begin
        write_reg(REG_SOURCE_WIDTH, DIM_W'(1));
        write_reg(REG_SOURCE_HEIGHT, DIM_W'(1));
        count = 20;
      end else if (kind == 9) begin
        write_reg(REG_SOURCE_WIDTH, ($urandom_range(0, 1) != 0) ? DIM_W'(4095) : DIM_W'(0));
        write_reg(REG_SOURCE_HEIGHT, ($urandom_range(0, 1) != 0) ? DIM_W'(4095) : DIM_W'(0));
        count = 40;
      end else begin
        write_reg(REG_SOURCE_WIDTH, DIM_W'($urandom_range(1, 4095)));
        write_reg(REG_SOURCE_HEIGHT, DIM_W'($urandom_range(1, 4095)));
        count = 40;
      end
      send_stream(count);
      settle();
    end

    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== ycbcr_to_rgb_framebuffer_writer.f =====
+incdir+design
design/ycrgbfw_pkg.sv
design/ycrgbfw_front.sv
design/ycrgbfw_fifo.sv
design/ycrgbfw_back.sv
design/ycbcr_to_rgb_framebuffer_writer.sv
bench/pixel_result_checker.sv
bench/tb.sv
